FILE: rtl/core/i2cram_pkg.sv
// shared types, sequence constants and unit decode for the i2c register access master
package i2cram_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WORD  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_START,
        K_WADDR,
        K_WREG,
        K_WDATA,
        K_WADDR_RD,
        K_RBYTE,
        K_STOP
    } kind_t;

    localparam logic [4:0] STEP_IDLE  = 5'd0;
    localparam logic [4:0] PROG_WRITE = 5'd1;
    localparam logic [4:0] PROG_READ  = 5'd6;
    localparam logic [4:0] PROG_WORD  = 5'd13;
    localparam logic [4:0] STOP_WRITE = 5'd5;
    localparam logic [4:0] STOP_READ  = 5'd12;
    localparam logic [4:0] STOP_WORD  = 5'd19;

    localparam logic [7:0] TARGET_ADDR_RESET = 8'd208;
    localparam logic [7:0] READ_BIT          = 8'h01;

    typedef struct packed {
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] reg_addr;
        action_t    action;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        nack;
        logic        done_res;
        logic        busy_res;
        logic        sda_out;
        logic        scl;
    } res_t;

    function automatic kind_t unit_kind(input logic [4:0] step);
        kind_t k;
        begin
            unique case (step)
                5'd1, 5'd6, 5'd9, 5'd13, 5'd16: k = K_START;
                5'd2, 5'd7, 5'd14:              k = K_WADDR;
                5'd3, 5'd8, 5'd15:              k = K_WREG;
                5'd4:                           k = K_WDATA;
                5'd10, 5'd17:                   k = K_WADDR_RD;
                5'd11, 5'd18:                   k = K_RBYTE;
                5'd5, 5'd12, 5'd19:             k = K_STOP;
                default:                        k = K_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] stop_of(input logic [4:0] step);
        logic [4:0] s;
        begin
            if (step <= STOP_WRITE) begin
                s = STOP_WRITE;
            end else if (step <= STOP_READ) begin
                s = STOP_READ;
            end else begin
                s = STOP_WORD;
            end
            return s;
        end
    endfunction

endpackage

FILE: rtl/core/i2cram_seq.sv
// transaction sequencer: bus phase state and line levels for one request per cycle while advance is high
module i2cram_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               advance,
    input  i2cram_pkg::req_t   req,
    output i2cram_pkg::res_t   res
);
    import i2cram_pkg::*;

    logic [4:0]  step_reg,        step_next;
    logic [1:0]  phase_reg,       phase_next;
    logic [3:0]  bit_cnt_reg,     bit_cnt_next;
    logic [7:0]  shift_reg,       shift_next;
    logic [7:0]  held_addr_reg,   held_addr_next;
    logic [7:0]  held_data_reg,   held_data_next;
    logic [15:0] read_result_reg, read_result_next;
    logic        second_half_reg, second_half_next;
    logic        saw_nack_reg,    saw_nack_next;
    logic [7:0]  target_addr_reg;
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        is_byte;
    logic        is_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg <= TARGET_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            target_addr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= STEP_IDLE;
            phase_reg       <= 2'd0;
            bit_cnt_reg     <= 4'd0;
            shift_reg       <= 8'd0;
            held_addr_reg   <= 8'd0;
            held_data_reg   <= 8'd0;
            read_result_reg <= 16'd0;
            second_half_reg <= 1'b0;
            saw_nack_reg    <= 1'b0;
        end
        else if (advance)
        begin
            step_reg        <= step_next;
            phase_reg       <= phase_next;
            bit_cnt_reg     <= bit_cnt_next;
            shift_reg       <= shift_next;
            held_addr_reg   <= held_addr_next;
            held_data_reg   <= held_data_next;
            read_result_reg <= read_result_next;
            second_half_reg <= second_half_next;
            saw_nack_reg    <= saw_nack_next;
        end
    end

    always_comb
    begin
        step_next        = step_reg;
        phase_next       = phase_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_next       = shift_reg;
        held_addr_next   = held_addr_reg;
        held_data_next   = held_data_reg;
        read_result_next = read_result_reg;
        second_half_next = second_half_reg;
        saw_nack_next    = saw_nack_reg;
        res              = '0;
        res.scl          = 1'b1;
        res.sda_out      = 1'b1;
        kind             = K_NONE;
        tx_byte          = target_addr_reg | READ_BIT;
        is_byte          = 1'b0;
        is_write         = 1'b0;

        // new request only from idle
        if (step_reg == STEP_IDLE && req.action != ACT_TICK)
        begin
            unique case (req.action)
                ACT_WRITE: step_next = PROG_WRITE;
                ACT_READ:  step_next = PROG_READ;
                default:   step_next = PROG_WORD;
            endcase
            phase_next       = 2'd0;
            bit_cnt_next     = 4'd0;
            held_addr_next   = req.reg_addr;
            held_data_next   = req.write_data;
            read_result_next = 16'd0;
            second_half_next = 1'b0;
            saw_nack_next    = 1'b0;
        end

        if (step_next != STEP_IDLE)
        begin
            kind         = unit_kind(step_next);
            res.busy_res = 1'b0 | 1'b1;
            is_write     = (kind == K_WADDR) || (kind == K_WREG) || (kind == K_WDATA)
                           || (kind == K_WADDR_RD);
            is_byte      = is_write || (kind == K_RBYTE);
            unique case (kind)
                K_WADDR: tx_byte = target_addr_reg;
                K_WREG:  tx_byte = held_addr_next;
                K_WDATA: tx_byte = held_data_next;
                default: tx_byte = target_addr_reg | READ_BIT;
            endcase

            unique case (kind)
                K_START:
                begin
                    res.scl     = phase_next[0] ^ phase_next[1];
                    res.sda_out = !phase_next[1];
                end
                K_STOP:
                begin
                    res.scl     = (phase_next != 2'd0);
                    res.sda_out = phase_next[1];
                end
                K_RBYTE:
                begin
                    res.scl     = phase_next[0] ^ phase_next[1];
                    res.sda_out = 1'b1;
                    if (!bit_cnt_next[3] && phase_next == 2'd2)
                    begin
                        shift_next = {shift_next[6:0], req.sda_in};
                        if (bit_cnt_next == 4'd7)
                        begin
                            if (step_next >= PROG_WORD && !second_half_next)
                            begin
                                read_result_next = {shift_next, 8'h00};
                            end
                            else if (step_next >= PROG_WORD)
                            begin
                                read_result_next = {read_result_next[15:8], shift_next};
                            end
                            else
                            begin
                                read_result_next = {8'h00, shift_next};
                            end
                        end
                    end
                end
                K_WADDR, K_WREG, K_WDATA, K_WADDR_RD:
                begin
                    res.scl     = phase_next[0] ^ phase_next[1];
                    res.sda_out = bit_cnt_next[3] ? 1'b1 : tx_byte[3'd7 - bit_cnt_next[2:0]];
                    if (bit_cnt_next[3] && phase_next == 2'd2)
                    begin
                        shift_next = {7'd0, req.sda_in};
                    end
                end
                default:
                begin
                    res.scl = 1'b1;
                end
            endcase

            if (phase_next != 2'd3)
            begin
                phase_next = phase_next + 2'd1;
            end
            else
            begin
                phase_next = 2'd0;
                if (is_byte && !bit_cnt_next[3])
                begin
                    bit_cnt_next = bit_cnt_next + 4'd1;
                end
                else
                begin
                    bit_cnt_next = 4'd0;
                    // missing acknowledge jumps to the stop of this program
                    if (is_write && shift_next[0])
                    begin
                        saw_nack_next = 1'b1;
                        step_next     = stop_of(step_next);
                    end
                    else if (kind == K_STOP)
                    begin
                        if (step_next == STOP_WORD && !second_half_next)
                        begin
                            second_half_next = 1'b1;
                            held_addr_next   = held_addr_next + 8'd1;
                            step_next        = PROG_WORD;
                        end
                        else
                        begin
                            res.done_res  = 1'b1;
                            res.nack      = saw_nack_next;
                            res.read_data = read_result_next;
                            step_next     = STEP_IDLE;
                        end
                    end
                    else
                    begin
                        step_next = step_next + 5'd1;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/i2c_register_access_master_unit.sv
// top level: request input register, phase sequencer and result output register
// path: a request is held in the input register, passes through the sequencer and is held in
// the result register before the result handshake
// throughput: one request per cycle while the result output is not stalled, set by the single-pass sequencer
// reset: asynchronous active low, returns to idle with device address 208 and empty registers
module i2c_register_access_master_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // reg_addr, write_data, sda_in, zero fill
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // scl, sda_out, busy_res, done_res, nack, read_data, fill
);
    import i2cram_pkg::*;

    logic in_valid_reg,  in_valid_next;
    logic out_valid_reg, out_valid_next;
    req_t in_data_reg;
    res_t out_data_reg;
    res_t seq_res;
    logic advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_valid_next  = (s_axis_tvalid && s_axis_tready) ? 1'b1
                          : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg.action     <= action_t'(s_axis_tuser);
            in_data_reg.reg_addr   <= s_axis_tdata[7:0];
            in_data_reg.write_data <= s_axis_tdata[15:8];
            in_data_reg.sda_in     <= s_axis_tdata[16];
        end
        if (advance)
        begin
            out_data_reg <= seq_res;
        end
    end

    i2cram_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .req       (in_data_reg),
        .res       (seq_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_data_reg};

endmodule
